// ----- src/lttb_downsampler_assert.svh -----
// Assertion macros used by the downsampler datapath.
`ifndef LTTB_DOWNSAMPLER_ASSERT_SVH
`define LTTB_DOWNSAMPLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LTTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lttb assertion failed");

// Next-cycle implication, disabled while reset is low.
`define LTTB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lttb assertion failed");

`endif

// ----- src/lttb_pkg.sv -----
// Shared constants, register indexes and controller/datapath interface types.
package lttb_pkg;

    localparam int MAX_BUCKET_DEF   = 256;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int BUCKET_MIN       = 8;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 9;

    localparam logic [CFG_IDX_W-1:0]  CFG_BUCKET_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_EXPLICIT_X  = 1'b1;
    localparam logic [CFG_DATA_W-1:0] BUCKET_RST      = 9'd8;

    typedef struct packed {
        logic accept;
        logic load_corner;
        logic prep;
        logic issue;
        logic emit_best;
        logic emit_hold;
    } t_cmd;

    typedef struct packed {
        logic started;
        logic pending;
        logic last;
        logic bucket_full;
        logic div_done;
        logic issue_last;
        logic pipe_empty;
        logic out_free;
        logic hold;
    } t_status;

endpackage

// ----- src/lttb_ctrl.sv -----
// Sequencer for accept, mean division, bucket scan and result emission.
module lttb_ctrl
    import lttb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_sample_valid,
    input  t_status i_st,
    output logic    o_sample_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIV    = 7'b0000010,
        S_PREP   = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_EMIT_A = 7'b0100000,
        S_EMIT_L = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc;

    assign o_sample_ready = (r_state == S_IDLE) && i_st.out_free;
    assign acc            = o_sample_ready && i_sample_valid;

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.accept      = acc;
        unique case (r_state)
            S_IDLE: begin
                if (acc && i_st.started) begin
                    if (i_st.last) begin
                        if (i_st.pending) n_state = S_PREP;
                    end else if (i_st.bucket_full && i_st.pending) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_st.div_done) begin
                    o_cmd.load_corner = 1'b1;
                    n_state           = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_st.issue_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_st.pipe_empty) n_state = S_EMIT_A;
            end
            S_EMIT_A: begin
                if (i_st.out_free) begin
                    o_cmd.emit_best = 1'b1;
                    n_state         = i_st.hold ? S_EMIT_L : S_IDLE;
                end
            end
            S_EMIT_L: begin
                if (i_st.out_free) begin
                    o_cmd.emit_hold = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/lttb_dpath.sv -----
// Bucket store, sums, mean divider, area scan pipeline and output register.
module lttb_dpath
    import lttb_pkg::*;
#(
    parameter int MAX_BUCKET   = MAX_BUCKET_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_x,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_y,
    input  logic                    i_last_sample,
    input  logic                    i_point_ready,
    input  t_cmd                    i_cmd,
    output t_status                 o_st,
    output logic                    o_point_valid,
    output logic [SAMPLE_WIDTH-1:0] o_point_x,
    output logic [SAMPLE_WIDTH-1:0] o_point_y,
    output logic                    o_end_of_series
);

    `include "lttb_downsampler_assert.svh"

    localparam int SW     = SAMPLE_WIDTH;
    localparam int IDX_W  = $clog2(MAX_BUCKET);
    localparam int CNT_W  = $clog2(MAX_BUCKET + 1);
    localparam int SUM_W  = SW + CNT_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int AW     = 2 * SW + 3;
    localparam int DEPTH  = 2 * (2 ** IDX_W);

    logic [CFG_DATA_W-1:0] r_cfg_bucket;
    logic                  r_cfg_explicit;
    logic [CNT_W-1:0]      r_run_size;
    logic                  r_run_explicit;
    logic                  r_started;
    logic                  r_pending;
    logic                  r_bank;
    logic                  r_pend_bank;
    logic [CNT_W-1:0]      r_fill;
    logic [SW-1:0]         r_index;
    logic [SUM_W-1:0]      r_sum_x;
    logic [SUM_W-1:0]      r_sum_y;
    logic [SW-1:0]         r_anchor_x;
    logic [SW-1:0]         r_anchor_y;
    logic                  r_hold;
    logic [SW-1:0]         r_hold_x;
    logic [SW-1:0]         r_hold_y;
    logic [SW-1:0]         r_corner_x;
    logic [SW-1:0]         r_corner_y;

    logic [DCNT_W-1:0]     r_div_cnt;
    logic [SUM_W-1:0]      r_qx;
    logic [SUM_W-1:0]      r_qy;
    logic [CNT_W-1:0]      r_remx;
    logic [CNT_W-1:0]      r_remy;
    logic                  r_negx;
    logic                  r_negy;

    logic [2*SW-1:0]       r_mem [0:DEPTH-1];
    logic [2*SW-1:0]       r_rd;
    logic [IDX_W-1:0]      r_scan_idx;
    logic signed [SW:0]    r_d2x;
    logic signed [SW:0]    r_d2y;
    logic                  r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [SW:0]    r_d1x;
    logic signed [SW:0]    r_d1y;
    logic [SW-1:0]         r_px2, r_py2, r_px3, r_py3, r_px4, r_py4, r_px5, r_py5;
    logic signed [2*SW+1:0] r_p1;
    logic signed [2*SW+1:0] r_p2;
    logic [AW-1:0]         r_cross;
    logic [AW-1:0]         r_area;
    logic [AW-1:0]         r_best;
    logic [SW-1:0]         r_best_x;
    logic [SW-1:0]         r_best_y;

    logic                  r_out_valid;
    logic [SW-1:0]         r_out_x;
    logic [SW-1:0]         r_out_y;
    logic                  r_out_eos;

    logic [31:0]           cfg_b32;
    logic [31:0]           run_b32;
    logic [SW-1:0]         x_first;
    logic [SW-1:0]         x_run;
    logic [SUM_W-1:0]      sum_x_nx;
    logic [SUM_W-1:0]      sum_y_nx;
    logic [SUM_W-1:0]      abs_x;
    logic [SUM_W-1:0]      abs_y;
    logic [CNT_W:0]        tx, ty;
    logic                  gex, gey;
    logic [SUM_W-1:0]      mean_x;
    logic [SUM_W-1:0]      mean_y;
    logic [CNT_W-1:0]      fill_inc;
    logic [CNT_W-1:0]      idx_inc;
    logic                  out_free;

    assign cfg_b32  = {{(32-CFG_DATA_W){1'b0}}, r_cfg_bucket};
    assign run_b32  = (cfg_b32 < 32'(BUCKET_MIN)) ? 32'(BUCKET_MIN) :
                      (cfg_b32 > 32'(MAX_BUCKET)) ? 32'(MAX_BUCKET) : cfg_b32;
    assign x_first  = r_cfg_explicit ? i_sample_x : '0;
    assign x_run    = r_run_explicit ? i_sample_x : r_index;
    assign sum_x_nx = r_sum_x + {{CNT_W{x_run[SW-1]}}, x_run};
    assign sum_y_nx = r_sum_y + {{CNT_W{i_sample_y[SW-1]}}, i_sample_y};
    assign abs_x    = sum_x_nx[SUM_W-1] ? (~sum_x_nx + 1'b1) : sum_x_nx;
    assign abs_y    = sum_y_nx[SUM_W-1] ? (~sum_y_nx + 1'b1) : sum_y_nx;
    assign tx       = {r_remx, r_qx[SUM_W-1]};
    assign ty       = {r_remy, r_qy[SUM_W-1]};
    assign gex      = tx >= {1'b0, r_run_size};
    assign gey      = ty >= {1'b0, r_run_size};
    assign mean_x   = r_negx ? (~r_qx + 1'b1) : r_qx;
    assign mean_y   = r_negy ? (~r_qy + 1'b1) : r_qy;
    assign fill_inc = r_fill + 1'b1;
    assign idx_inc  = {{(CNT_W-IDX_W){1'b0}}, r_scan_idx} + 1'b1;
    assign out_free = !r_out_valid || i_point_ready;

    assign o_st.started     = r_started;
    assign o_st.pending     = r_pending;
    assign o_st.last        = i_last_sample;
    assign o_st.bucket_full = fill_inc >= r_run_size;
    assign o_st.div_done    = (r_div_cnt == '0);
    assign o_st.issue_last  = (idx_inc == r_run_size);
    assign o_st.pipe_empty  = !(r_v1 || r_v2 || r_v3 || r_v4 || r_v5);
    assign o_st.out_free    = out_free;
    assign o_st.hold        = r_hold;

    assign o_point_valid   = r_out_valid;
    assign o_point_x       = r_out_x;
    assign o_point_y       = r_out_y;
    assign o_end_of_series = r_out_eos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bucket   <= BUCKET_RST;
            r_cfg_explicit <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BUCKET_SIZE: r_cfg_bucket   <= i_cfg_data;
                CFG_EXPLICIT_X:  r_cfg_explicit <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sample intake, bucket bookkeeping and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_size     <= CNT_W'(BUCKET_MIN);
            r_run_explicit <= 1'b1;
            r_started      <= 1'b0;
            r_pending      <= 1'b0;
            r_bank         <= 1'b0;
            r_pend_bank    <= 1'b0;
            r_fill         <= '0;
            r_index        <= '0;
            r_sum_x        <= '0;
            r_sum_y        <= '0;
            r_anchor_x     <= '0;
            r_anchor_y     <= '0;
            r_hold         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (r_out_valid && i_point_ready) r_out_valid <= 1'b0;
            if (i_cmd.accept) begin
                if (!r_started) begin
                    r_run_size     <= run_b32[CNT_W-1:0];
                    r_run_explicit <= r_cfg_explicit;
                    r_index        <= SW'(1);
                    r_anchor_x     <= x_first;
                    r_anchor_y     <= i_sample_y;
                    r_out_valid    <= 1'b1;
                    r_out_x        <= x_first;
                    r_out_y        <= i_sample_y;
                    r_out_eos      <= i_last_sample;
                    r_sum_x        <= '0;
                    r_sum_y        <= '0;
                    r_fill         <= '0;
                    r_bank         <= 1'b0;
                    r_pending      <= 1'b0;
                    r_hold         <= 1'b0;
                    r_started      <= !i_last_sample;
                end else begin
                    r_index <= r_index + 1'b1;
                    if (i_last_sample) begin
                        if (r_pending) begin
                            r_hold     <= 1'b1;
                            r_hold_x   <= x_run;
                            r_hold_y   <= i_sample_y;
                            r_corner_x <= x_run;
                            r_corner_y <= i_sample_y;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_x     <= x_run;
                            r_out_y     <= i_sample_y;
                            r_out_eos   <= 1'b1;
                        end
                        r_started <= 1'b0;
                        r_pending <= 1'b0;
                        r_fill    <= '0;
                        r_sum_x   <= '0;
                        r_sum_y   <= '0;
                    end else if (fill_inc >= r_run_size) begin
                        if (!r_pending) r_pend_bank <= r_bank;
                        r_pending   <= 1'b1;
                        r_bank      <= ~r_bank;
                        r_fill      <= '0;
                        r_sum_x     <= '0;
                        r_sum_y     <= '0;
                    end else begin
                        r_fill  <= fill_inc;
                        r_sum_x <= sum_x_nx;
                        r_sum_y <= sum_y_nx;
                    end
                end
            end
            if (i_cmd.load_corner) begin
                r_corner_x <= mean_x[SW-1:0];
                r_corner_y <= mean_y[SW-1:0];
            end
            // advance the pending bank to the bucket whose closing started this scan
            if (i_cmd.emit_best) begin
                r_pend_bank <= ~r_pend_bank;
                r_anchor_x  <= r_best_x;
                r_anchor_y  <= r_best_y;
                r_out_valid <= 1'b1;
                r_out_x     <= r_best_x;
                r_out_y     <= r_best_y;
                r_out_eos   <= 1'b0;
            end
            if (i_cmd.emit_hold) begin
                r_hold      <= 1'b0;
                r_out_valid <= 1'b1;
                r_out_x     <= r_hold_x;
                r_out_y     <= r_hold_y;
                r_out_eos   <= 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle for both means
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.accept && r_started && !i_last_sample && r_pending &&
                     (fill_inc >= r_run_size)) begin
            r_div_cnt <= DCNT_W'(SUM_W);
            r_qx      <= abs_x;
            r_qy      <= abs_y;
            r_negx    <= sum_x_nx[SUM_W-1];
            r_negy    <= sum_y_nx[SUM_W-1];
            r_remx    <= '0;
            r_remy    <= '0;
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
            r_remx    <= gex ? CNT_W'(tx - {1'b0, r_run_size}) : tx[CNT_W-1:0];
            r_remy    <= gey ? CNT_W'(ty - {1'b0, r_run_size}) : ty[CNT_W-1:0];
            r_qx      <= {r_qx[SUM_W-2:0], gex};
            r_qy      <= {r_qy[SUM_W-2:0], gey};
        end
    end

    // bucket store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_started && !i_last_sample) begin
            r_mem[{r_bank, r_fill[IDX_W-1:0]}] <= {x_run, i_sample_y};
        end
        if (i_cmd.issue) begin
            r_rd <= r_mem[{r_pend_bank, r_scan_idx}];
        end
    end

    // scan pipeline: read, differences, products, cross term, magnitude, compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_scan_idx <= '0;
            r_d2x      <= $signed({r_corner_x[SW-1], r_corner_x}) -
                          $signed({r_anchor_x[SW-1], r_anchor_x});
            r_d2y      <= $signed({r_corner_y[SW-1], r_corner_y}) -
                          $signed({r_anchor_y[SW-1], r_anchor_y});
            r_best     <= '0;
            r_best_x   <= '0;
            r_best_y   <= '0;
        end else begin
            if (i_cmd.issue) r_scan_idx <= r_scan_idx + 1'b1;
            if (r_v5 && (r_area >= r_best)) begin
                r_best   <= r_area;
                r_best_x <= r_px5;
                r_best_y <= r_py5;
            end
        end
        r_px2   <= r_rd[2*SW-1:SW];
        r_py2   <= r_rd[SW-1:0];
        r_d1x   <= $signed({r_rd[2*SW-1], r_rd[2*SW-1:SW]}) -
                   $signed({r_anchor_x[SW-1], r_anchor_x});
        r_d1y   <= $signed({r_rd[SW-1], r_rd[SW-1:0]}) -
                   $signed({r_anchor_y[SW-1], r_anchor_y});
        r_px3   <= r_px2;
        r_py3   <= r_py2;
        r_p1    <= r_d1x * r_d2y;
        r_p2    <= r_d1y * r_d2x;
        r_px4   <= r_px3;
        r_py4   <= r_py3;
        r_cross <= {r_p1[2*SW+1], r_p1} - {r_p2[2*SW+1], r_p2};
        r_px5   <= r_px4;
        r_py5   <= r_py4;
        r_area  <= r_cross[AW-1] ? (~r_cross + 1'b1) : r_cross;
    end

    `LTTB_ASSERT_NXT(a_first_passes, i_clk, i_rst_n, i_cmd.accept && !r_started, r_out_valid && o_point_x == r_anchor_x && o_point_y == r_anchor_y)
    `LTTB_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill < r_run_size)
    `LTTB_ASSERT_IMP(a_hold_emit, i_clk, i_rst_n, i_cmd.emit_hold, r_hold)

endmodule

// ----- src/lttb_downsampler.sv -----
// Top level of the streaming largest-triangle-three-buckets downsampler.
// A first point, or a last point with no pending bucket, goes straight to the output register; a
// bucket closing with another pending runs the divider, setup, scan, drain and an emit; a last
// sample with a pending bucket skips the divider and emits the last point after the scan's point.
// Throughput: 1 sample per cycle while filling, output free; input stalls from divide to emit.
// Reset (synchronous, active low) clears control state and loads bucket size 8, explicit x on.
module lttb_downsampler
    import lttb_pkg::*;
#(
    parameter int MAX_BUCKET   = MAX_BUCKET_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_sample_valid,
    output logic                    o_sample_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_x,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_y,
    input  logic                    i_last_sample,
    output logic                    o_point_valid,
    input  logic                    i_point_ready,
    output logic [SAMPLE_WIDTH-1:0] o_point_x,
    output logic [SAMPLE_WIDTH-1:0] o_point_y,
    output logic                    o_end_of_series
);

    t_cmd    cmd;
    t_status st;

    lttb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .i_st           (st),
        .o_sample_ready (o_sample_ready),
        .o_cmd          (cmd)
    );

    lttb_dpath #(
        .MAX_BUCKET   (MAX_BUCKET),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample_x      (i_sample_x),
        .i_sample_y      (i_sample_y),
        .i_last_sample   (i_last_sample),
        .i_point_ready   (i_point_ready),
        .i_cmd           (cmd),
        .o_st            (st),
        .o_point_valid   (o_point_valid),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_end_of_series (o_end_of_series)
    );

endmodule

// ----- test/lttb_downsampler_test.sv -----
// Self-checking testbench for the streaming LTTB downsampler with a built-in predictor.
module lttb_downsampler_test;
    import lttb_pkg::*;

    localparam int BANK_DEPTH = MAX_BUCKET_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
    } t_sample;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        eos;
    } t_point;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_sample_valid = 1'b0;
    logic                  o_sample_ready;
    logic [31:0]           i_sample_x = '0;
    logic [31:0]           i_sample_y = '0;
    logic                  i_last_sample = 1'b0;
    logic                  o_point_valid;
    logic                  i_point_ready = 1'b0;
    logic [31:0]           o_point_x;
    logic [31:0]           o_point_y;
    logic                  o_end_of_series;

    lttb_downsampler dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_sample samples_to_send[$];
    t_point  expected_points[$];
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      failed = 1'b0;
    int      quiet_cycles = 0;

    // predictor state
    longint  bank_x[0:3*BANK_DEPTH-1];
    longint  bank_y[0:3*BANK_DEPTH-1];
    longint  acc_x, acc_y, anchor_x, anchor_y;
    int      fill, bank_sel, scan_bank, live_size;
    bit      bucket_waiting, in_series, live_explicit;
    logic [31:0] index_x;
    logic [8:0]  size_reg = BUCKET_RST;
    bit          explicit_reg = 1'b1;

    initial begin
        acc_x = 0; acc_y = 0; anchor_x = 0; anchor_y = 0;
        fill = 0; bank_sel = 0; scan_bank = 0; live_size = 8;
        bucket_waiting = 0; in_series = 0; live_explicit = 1; index_x = '0;
    end

    function automatic int clamp_size(logic [8:0] raw);
        if (raw < BUCKET_MIN) return BUCKET_MIN;
        if (raw > BANK_DEPTH) return BANK_DEPTH;
        return int'(raw);
    endfunction

    function automatic void push_point(longint x, longint y, bit eos);
        t_point p;
        p.x = x[31:0];
        p.y = y[31:0];
        p.eos = eos;
        expected_points.push_back(p);
    endfunction

    // pick the point of the waiting bucket with the largest triangle, later wins ties
    function automatic void pick_best(longint cx, longint cy);
        logic signed [69:0] d1x, d1y, d2x, d2y, area, best;
        longint bx, by;
        int base;
        base = scan_bank * BANK_DEPTH;
        d2x = cx - anchor_x;
        d2y = cy - anchor_y;
        best = 0;
        bx = 0;
        by = 0;
        for (int i = 0; i < live_size; i++) begin
            d1x = bank_x[base+i] - anchor_x;
            d1y = bank_y[base+i] - anchor_y;
            area = d1x * d2y - d1y * d2x;
            if (area < 0) area = -area;
            if (area >= best) begin
                best = area;
                bx = bank_x[base+i];
                by = bank_y[base+i];
            end
        end
        anchor_x = bx;
        anchor_y = by;
    endfunction

    function automatic void predict_sample(t_sample s);
        longint x, y;
        int slot;
        y = longint'($signed(s.y));
        if (!in_series) begin
            live_size = clamp_size(size_reg);
            live_explicit = explicit_reg;
            x = live_explicit ? longint'($signed(s.x)) : 0;
            anchor_x = x;
            anchor_y = y;
            push_point(x, y, s.last);
            acc_x = 0; acc_y = 0; fill = 0; bank_sel = 0;
            bucket_waiting = 0;
            in_series = !s.last;
            index_x = 32'd1;
            return;
        end
        x = live_explicit ? longint'($signed(s.x)) : longint'($signed(index_x));
        index_x = index_x + 32'd1;
        if (s.last) begin
            if (bucket_waiting) begin
                pick_best(x, y);
                push_point(anchor_x, anchor_y, 1'b0);
            end
            push_point(x, y, 1'b1);
            in_series = 0; bucket_waiting = 0; fill = 0; acc_x = 0; acc_y = 0;
            return;
        end
        slot = bank_sel * BANK_DEPTH + fill;
        bank_x[slot] = x;
        bank_y[slot] = y;
        acc_x += x;
        acc_y += y;
        fill++;
        if (fill >= live_size) begin
            if (bucket_waiting) begin
                pick_best(acc_x / live_size, acc_y / live_size);
                push_point(anchor_x, anchor_y, 1'b0);
            end
            scan_bank = bank_sel;
            bucket_waiting = 1;
            bank_sel = (bank_sel + 1) % 3;
            fill = 0; acc_x = 0; acc_y = 0;
        end
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        t_sample s;
        if (!i_rst_n) begin
            i_sample_valid <= 1'b0;
        end else begin
            if (i_sample_valid && o_sample_ready) begin
                s.x = i_sample_x;
                s.y = i_sample_y;
                s.last = i_last_sample;
                predict_sample(s);
            end
            if (!i_sample_valid || o_sample_ready) begin
                if (samples_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s = samples_to_send.pop_front();
                    i_sample_valid <= 1'b1;
                    i_sample_x <= s.x;
                    i_sample_y <= s.y;
                    i_last_sample <= s.last;
                end else begin
                    i_sample_valid <= 1'b0;
                end
            end
        end
    end

    // point monitor
    always @(posedge i_clk) begin
        t_point p;
        if (!i_rst_n) begin
            i_point_ready <= 1'b0;
        end else begin
            i_point_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_point_valid && i_point_ready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected point x=%h y=%h eos=%b", $time,
                             o_point_x, o_point_y, o_end_of_series);
                    failed = 1'b1;
                end else begin
                    p = expected_points.pop_front();
                    if (o_point_x !== p.x || o_point_y !== p.y || o_end_of_series !== p.eos) begin
                        $display("%0t: point mismatch expected x=%h y=%h eos=%b actual x=%h y=%h eos=%b",
                                 $time, p.x, p.y, p.eos, o_point_x, o_point_y, o_end_of_series);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_sample_valid && o_sample_ready) || (o_point_valid && i_point_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord(bit full_range);
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return full_range ? $urandom : 32'($urandom_range(8)) - 32'd4;
        endcase
    endfunction

    function automatic void add_sample(logic [31:0] x, logic [31:0] y, bit last);
        t_sample s;
        s.x = x;
        s.y = y;
        s.last = last;
        samples_to_send.push_back(s);
    endfunction

    function automatic int add_series(int len);
        bit full_range;
        full_range = $urandom_range(1);
        for (int i = 0; i < len; i++)
            add_sample(pick_coord(full_range), pick_coord(full_range), i == len - 1);
        return len;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        if (idx == CFG_BUCKET_SIZE) size_reg = value;
        else explicit_reg = value[0];
    endtask

    task automatic drain();
        while (samples_to_send.size() > 0 || i_sample_valid || expected_points.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int sizes[8] = '{0, 12, 511, 9, 3, 256, 16, 8};
        int xmode[8] = '{0, 1, 1, 0, 1, 0, 1, 1};
        int count, b, len;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CFG_BUCKET_SIZE, 9'd8);
        write_reg(CFG_EXPLICIT_X, 9'd1);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;

        // lone sample, two-sample series, then two full buckets with extremes and a stub
        add_sample(32'h8000_0000, 32'h7fff_ffff, 1'b1);
        add_sample(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        add_sample(32'h0000_0000, 32'hffff_ffff, 1'b1);
        add_sample(32'h0, 32'h0, 1'b0);
        for (int i = 0; i < 18; i++)
            add_sample(i[0] ? 32'h7fff_ffff : 32'h8000_0000,
                       i[1] ? 32'h8000_0000 : 32'h7fff_ffff, 1'b0);
        add_sample(32'h1, 32'h1, 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 34 : 67) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 34 : 67) : 0;
            write_reg(CFG_BUCKET_SIZE, 9'(sizes[ph]));
            write_reg(CFG_EXPLICIT_X, 9'(xmode[ph]));
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            b = clamp_size(9'(sizes[ph]));
            count = 0;
            if (b == BANK_DEPTH && ph == 2) begin
                count += add_series(b + 2);
            end
            while (count < 8) begin
                case ($urandom_range(5))
                    0: len = $urandom_range(1, 2);
                    default: len = 1 + $urandom_range(1, 3) * (b > 16 ? 1 : b)
                                   + $urandom_range(b > 16 ? 40 : b);
                endcase
                count += add_series(len);
            end
            // leave the last series open so the next settings land mid-series
            count += add_series($urandom_range(2, 6));
            samples_to_send.push_back('{32'h5, 32'h5, 1'b0});
            drain();
        end
        samples_to_send.push_back('{32'h9, 32'h9, 1'b1});
        drain();

        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
